@@ sv/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// Trajectory segment splitter package
// Shared widths, command codes and constants of the segment splitter.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TSS_MAX_BOUNDARIES = 16;
    localparam int TSS_MAX_POINTS     = 65536;

    localparam int ID_W     = 16;
    localparam int COORD_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int INDEX_W  = 16;
    localparam int NUMBER_W = 16;
    localparam int MASK_W   = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic [MASK_W-1:0] FULL_MASK = 4'hF;

    localparam int QUAD_PP = 0;
    localparam int QUAD_NP = 1;
    localparam int QUAD_NN = 2;
    localparam int QUAD_PN = 3;

endpackage

@@ sv/tss_channels.sv @@
// ----------------------------------------------------------------------------
// Trajectory segment splitter channels
// Valid/ready channels for points, segment results and configuration.
// ----------------------------------------------------------------------------
interface tss_point_if;
    import tss_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [SLOT_W-1:0]           table_slot;
    logic [ID_W-1:0]             traj_id;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic [STAMP_W-1:0]          stamp;

    modport source (output valid, cmd, table_slot, traj_id, pos_x, pos_y, stamp,
                    input ready);
    modport sink   (input valid, cmd, table_slot, traj_id, pos_x, pos_y, stamp,
                    output ready);
endinterface

interface tss_seg_if;
    import tss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_W-1:0]    seg_start;
    logic [STAMP_W-1:0]    seg_time;
    logic [NUMBER_W-1:0]   seg_number;

    modport source (output valid, seg_start, seg_time, seg_number, input ready);
    modport sink   (input valid, seg_start, seg_time, seg_number, output ready);
endinterface

interface tss_cfg_if;
    import tss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/trajectory_segment_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// Trajectory segment splitter: cuts a point stream into segments by id, direction and time.
// Items are taken only in S_IDLE, where a load is written; a point then passes S_CMP_X,
// S_CMP_Y and S_WALK; the table walk steps the shared comparator, one entry per cycle, over
// each crossed boundary. Results register once the output is free. Reset is asynchronous.
// ----------------------------------------------------------------------------
module trajectory_segment_splitter_unit #(
    parameter int MAX_BOUNDARIES = tss_pkg::TSS_MAX_BOUNDARIES,
    parameter int MAX_POINTS     = tss_pkg::TSS_MAX_POINTS
) (
    input  logic      clk,
    input  logic      rst_n,
    tss_point_if.sink point,
    tss_seg_if.source seg,
    tss_cfg_if.sink   cfg
);
    import tss_pkg::*;

    localparam int AW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
    localparam int CW = $clog2(MAX_BOUNDARIES + 1);
    localparam int PW = $clog2(MAX_POINTS);

    typedef enum logic [1:0] {S_IDLE, S_CMP_X, S_CMP_Y, S_WALK} state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  id_seen_reg, id_seen_next;
    logic [ID_W-1:0]       last_id_reg, last_id_next;
    logic [COORD_W-1:0]    prev_x_reg, prev_x_next;
    logic [COORD_W-1:0]    prev_y_reg, prev_y_next;
    logic [COORD_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic [STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [MASK_W-1:0]     dir_mask_reg, dir_mask_next;
    logic [CW-1:0]         slot_reg, slot_next;
    logic [PW-1:0]         point_cnt_reg, point_cnt_next;
    logic [NUMBER_W-1:0]   seg_cnt_reg, seg_cnt_next;
    logic                  new_id_reg, new_id_next;
    logic                  moved_reg, moved_next;
    logic                  x_ge_reg, x_ge_next;
    logic                  x_le_reg, x_le_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    out_start_reg, out_start_next;
    logic [STAMP_W-1:0]    out_time_reg, out_time_next;
    logic [NUMBER_W-1:0]   out_number_reg, out_number_next;

    logic [STAMP_W-1:0]    bnd_mem [MAX_BOUNDARIES];
    logic [STAMP_W-1:0]    rd_data_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;

    logic [COORD_W-1:0]    op_a;
    logic [COORD_W-1:0]    op_b;
    logic                  op_signed;
    logic signed [COORD_W:0] op_a_ext;
    logic signed [COORD_W:0] op_b_ext;
    logic                  cmp_lt;
    logic                  cmp_eq;

    logic [CW-1:0]         valid_cnt;
    logic                  point_xfer;
    logic                  y_ge;
    logic                  y_le;
    logic [MASK_W-1:0]     quad;
    logic                  cut;
    logic                  out_free;

    assign point.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign seg.valid      = out_valid_reg;
    assign seg.seg_start  = out_start_reg;
    assign seg.seg_time   = out_time_reg;
    assign seg.seg_number = out_number_reg;

    assign point_xfer = point.valid && point.ready;
    assign out_free   = !out_valid_reg || seg.ready;

    assign valid_cnt = (32'(count_reg) > MAX_BOUNDARIES) ? CW'(MAX_BOUNDARIES)
                                                         : CW'(count_reg);

    assign wr_en   = point_xfer && (point.cmd == CMD_LOAD)
                     && (32'(point.table_slot) < MAX_BOUNDARIES);
    assign wr_addr = AW'(32'(point.table_slot));
    assign rd_addr = AW'(slot_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bnd_mem[wr_addr] <= point.stamp;
        end
        rd_data_reg <= bnd_mem[rd_addr];
    end

    // Shared comparator: one signed or unsigned 32-bit compare per cycle.
    always_comb
    begin
        unique case (state_reg)
            S_CMP_X:
            begin
                op_a      = x_reg;
                op_b      = prev_x_reg;
                op_signed = 1'b1;
            end
            S_CMP_Y:
            begin
                op_a      = y_reg;
                op_b      = prev_y_reg;
                op_signed = 1'b1;
            end
            default:
            begin
                op_a      = rd_data_reg;
                op_b      = stamp_reg;
                op_signed = 1'b0;
            end
        endcase
        op_a_ext = $signed({op_signed & op_a[COORD_W-1], op_a});
        op_b_ext = $signed({op_signed & op_b[COORD_W-1], op_b});
        cmp_lt   = (op_a_ext < op_b_ext);
        cmp_eq   = (op_a == op_b);
    end

    assign y_ge = !cmp_lt;
    assign y_le = cmp_lt || cmp_eq;

    always_comb
    begin
        quad          = '0;
        quad[QUAD_PP] = x_ge_reg && y_ge;
        quad[QUAD_PN] = x_ge_reg && y_le;
        quad[QUAD_NP] = x_le_reg && y_ge;
        quad[QUAD_NN] = x_le_reg && y_le;
    end

    assign cut = new_id_reg || moved_reg || (dir_mask_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        id_seen_next    = id_seen_reg;
        last_id_next    = last_id_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        stamp_next      = stamp_reg;
        dir_mask_next   = dir_mask_reg;
        slot_next       = slot_reg;
        point_cnt_next  = point_cnt_reg;
        seg_cnt_next    = seg_cnt_reg;
        new_id_next     = new_id_reg;
        moved_next      = moved_reg;
        x_ge_next       = x_ge_reg;
        x_le_next       = x_le_reg;
        out_valid_next  = out_valid_reg && !seg.ready;
        out_start_next  = out_start_reg;
        out_time_next   = out_time_reg;
        out_number_next = out_number_reg;

        if (cfg.valid && cfg.ready)
        begin
            count_next = cfg.data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_xfer && (point.cmd == CMD_POINT))
                begin
                    x_next     = point.pos_x;
                    y_next     = point.pos_y;
                    stamp_next = point.stamp;
                    moved_next = 1'b0;
                    if (!id_seen_reg || (point.traj_id > last_id_reg))
                    begin
                        new_id_next  = 1'b1;
                        id_seen_next = 1'b1;
                        last_id_next = point.traj_id;
                        slot_next    = '0;
                    end
                    else
                    begin
                        new_id_next = 1'b0;
                    end
                    state_next = S_CMP_X;
                end
            end
            S_CMP_X:
            begin
                x_ge_next  = !cmp_lt;
                x_le_next  = cmp_lt || cmp_eq;
                state_next = S_CMP_Y;
            end
            S_CMP_Y:
            begin
                if (!new_id_reg)
                begin
                    dir_mask_next = dir_mask_reg & quad;
                end
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if ((slot_reg < valid_cnt) && (cmp_lt || cmp_eq))
                begin
                    slot_next  = slot_reg + 1'b1;
                    moved_next = !new_id_reg;
                end
                else if (out_free)
                begin
                    prev_x_next = x_reg;
                    prev_y_next = y_reg;
                    if (point_cnt_reg == PW'(MAX_POINTS - 1))
                    begin
                        point_cnt_next = '0;
                    end
                    else
                    begin
                        point_cnt_next = point_cnt_reg + 1'b1;
                    end
                    if (cut)
                    begin
                        dir_mask_next   = FULL_MASK;
                        out_valid_next  = 1'b1;
                        out_start_next  = INDEX_W'(point_cnt_reg);
                        out_time_next   = stamp_reg;
                        out_number_next = seg_cnt_reg;
                        seg_cnt_next    = seg_cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            id_seen_reg    <= 1'b0;
            last_id_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            stamp_reg      <= '0;
            dir_mask_reg   <= FULL_MASK;
            slot_reg       <= '0;
            point_cnt_reg  <= '0;
            seg_cnt_reg    <= '0;
            new_id_reg     <= 1'b0;
            moved_reg      <= 1'b0;
            x_ge_reg       <= 1'b0;
            x_le_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_start_reg  <= '0;
            out_time_reg   <= '0;
            out_number_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            id_seen_reg    <= id_seen_next;
            last_id_reg    <= last_id_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            stamp_reg      <= stamp_next;
            dir_mask_reg   <= dir_mask_next;
            slot_reg       <= slot_next;
            point_cnt_reg  <= point_cnt_next;
            seg_cnt_reg    <= seg_cnt_next;
            new_id_reg     <= new_id_next;
            moved_reg      <= moved_next;
            x_ge_reg       <= x_ge_next;
            x_le_reg       <= x_le_next;
            out_valid_reg  <= out_valid_next;
            out_start_reg  <= out_start_next;
            out_time_reg   <= out_time_next;
            out_number_reg <= out_number_next;
        end
    end

    // A pending result always carries the segment number just issued.
    a_seg_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (seg_cnt_reg == out_number_reg + 1'b1))
        else $error("pending segment number out of step with segment counter");

    // An empty direction mask never survives past the end of a point.
    a_mask_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (dir_mask_reg != '0))
        else $error("direction mask left empty after a point");

    // The time slot moves only during the table walk or on a new id.
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP_X || state_reg == S_CMP_Y) |=> $stable(slot_reg))
        else $error("time slot changed outside the table walk");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trajectory segment splitter regression bench
// Drives boundary loads and trajectory points into the splitter, predicts every
// segment cut from a private copy of the splitter state and compares each
// segment transfer with the oldest prediction. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 32;
    localparam int CYCLE_LIMIT      = 4000000;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PHASES    = 6;
    localparam int TRACK_ITEMS      = 66;
    localparam int LONG_TRACK_POINTS = 20;

    typedef struct {
        logic                      cmd;
        logic [SLOT_W-1:0]         slot;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [STAMP_W-1:0]        stamp;
    } track_point_t;

    typedef struct {
        logic [INDEX_W-1:0]  start_idx;
        logic [STAMP_W-1:0]  open_time;
        logic [NUMBER_W-1:0] seg_no;
    } segment_t;

    logic clk;
    logic rst_n;

    tss_point_if point_ch ();
    tss_seg_if   seg_ch ();
    tss_cfg_if   cfg_ch ();

    trajectory_segment_splitter_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_ch),
        .seg   (seg_ch),
        .cfg   (cfg_ch)
    );

    logic [STAMP_W-1:0]        bnd_value [TSS_MAX_BOUNDARIES];
    logic [COUNT_W-1:0]        bnd_count;
    int                        cur_id;
    logic signed [COORD_W-1:0] last_x;
    logic signed [COORD_W-1:0] last_y;
    logic [MASK_W-1:0]         heading;
    int                        slot_pos;
    logic [INDEX_W-1:0]        point_idx;
    logic [NUMBER_W-1:0]       seg_idx;
    segment_t                  pending_segments [$];

    bit no_idle;
    int ready_hold;
    int errors;
    int cycle_count;
    int n_loads;
    int n_points;
    int n_checked;
    int n_cfg;

    always #HALF_PERIOD clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic void report_failure(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic logic [MASK_W-1:0] step_quadrants(
        input logic signed [COORD_W-1:0] x0,
        input logic signed [COORD_W-1:0] y0,
        input logic signed [COORD_W-1:0] x1,
        input logic signed [COORD_W-1:0] y1
    );
        logic [MASK_W-1:0] q;
        q = '0;
        if (x1 >= x0)
        begin
            if (y1 >= y0) q[QUAD_PP] = 1'b1;
            if (y1 <= y0) q[QUAD_PN] = 1'b1;
        end
        if (x1 <= x0)
        begin
            if (y1 >= y0) q[QUAD_NP] = 1'b1;
            if (y1 <= y0) q[QUAD_NN] = 1'b1;
        end
        return q;
    endfunction

    function automatic bit advance_slots(input logic [STAMP_W-1:0] t);
        int  limit;
        bit  moved;
        limit = (bnd_count > TSS_MAX_BOUNDARIES) ? TSS_MAX_BOUNDARIES : int'(bnd_count);
        moved = 1'b0;
        while (slot_pos < limit && bnd_value[slot_pos] <= t)
        begin
            slot_pos++;
            moved = 1'b1;
        end
        return moved;
    endfunction

    task automatic split_point(input track_point_t p);
        bit                 cut;
        bit                 crossed;
        logic [INDEX_W-1:0] idx;
        segment_t           s;
        if (p.cmd == CMD_LOAD)
        begin
            bnd_value[p.slot] = p.stamp;
            n_loads++;
            return;
        end
        n_points++;
        idx = point_idx;
        cut = 1'b0;
        if (int'(p.id) > cur_id)
        begin
            cur_id   = int'(p.id);
            slot_pos = 0;
            void'(advance_slots(p.stamp));
            heading  = FULL_MASK;
            cut      = 1'b1;
        end
        else
        begin
            heading = heading & step_quadrants(last_x, last_y, p.x, p.y);
            crossed = advance_slots(p.stamp);
            if (heading == '0 || crossed)
            begin
                heading = FULL_MASK;
                cut     = 1'b1;
            end
        end
        last_x    = p.x;
        last_y    = p.y;
        point_idx = point_idx + 1'b1;
        if (cut)
        begin
            s.start_idx = idx;
            s.open_time = p.stamp;
            s.seg_no    = seg_idx;
            pending_segments.push_back(s);
            seg_idx = seg_idx + 1'b1;
        end
    endtask

    function automatic track_point_t make_point(
        input logic [ID_W-1:0]         id,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [STAMP_W-1:0]      t
    );
        track_point_t p;
        p.cmd   = CMD_POINT;
        p.slot  = SLOT_W'($urandom_range(0, 15));
        p.id    = id;
        p.x     = x;
        p.y     = y;
        p.stamp = t;
        return p;
    endfunction

    function automatic track_point_t make_load(
        input logic [SLOT_W-1:0]  slot,
        input logic [STAMP_W-1:0] value
    );
        track_point_t p;
        p.cmd   = CMD_LOAD;
        p.slot  = slot;
        p.id    = ID_W'($urandom_range(0, 65535));
        p.x     = $urandom();
        p.y     = $urandom();
        p.stamp = value;
        return p;
    endfunction

    task automatic send_item(input track_point_t p);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_ch.cmd        <= p.cmd;
        point_ch.table_slot <= p.slot;
        point_ch.traj_id    <= p.id;
        point_ch.pos_x      <= p.x;
        point_ch.pos_y      <= p.y;
        point_ch.stamp      <= p.stamp;
        point_ch.valid      <= 1'b1;
        do @(posedge clk); while (point_ch.ready !== 1'b1);
        split_point(p);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        point_ch.valid <= 1'b0;
        while (pending_segments.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        bnd_count = value;
        n_cfg++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_direction_cut();
        send_item(make_point(16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0));
        send_item(make_point(16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd1));
        send_item(make_point(16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd2));
        send_item(make_point(16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd3));
    endtask

    task automatic test_boundary_crossing();
        logic [ID_W-1:0] tid;
        send_item(make_load(4'd0, 32'd0));
        send_item(make_load(4'd1, 32'd100));
        send_item(make_load(4'd2, 32'd300));
        send_item(make_load(4'd3, 32'hFFFF_FFFF));
        write_count(5'd4);
        tid = ID_W'(cur_id + 1);
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd50));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd100));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd150));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd400));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'hFFFF_FFFF));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd7));
        send_item(make_point(16'd0, 32'sd5, 32'sd5, 32'd8));
        send_item(make_point(tid, 32'sd5, 32'sd5, 32'd9));
    endtask

    task automatic test_random_tracks();
        int                        phase;
        int                        sent;
        int                        len;
        int                        k;
        int                        r;
        int                        base;
        int                        spacing;
        int                        dir_x;
        int                        dir_y;
        logic [ID_W-1:0]           tid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [STAMP_W-1:0]        t;
        logic [STAMP_W-1:0]        v;
        logic [COUNT_W-1:0]        setting;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            no_idle = (phase == 0);
            base    = $urandom_range(0, 4000);
            spacing = $urandom_range(50, 2000);
            v       = base;
            for (k = 0; k < TSS_MAX_BOUNDARIES; k++)
            begin
                if (phase == RANDOM_PHASES - 1)
                begin
                    v = $urandom();
                end
                else
                begin
                    v = v + $urandom_range(1, 2 * spacing);
                end
                send_item(make_load(SLOT_W'(k), v));
            end
            case (phase)
                0:       setting = COUNT_W'(TSS_MAX_BOUNDARIES);
                1:       setting = COUNT_W'($urandom_range(1, 15));
                2:       setting = '0;
                3:       setting = '1;
                4:       setting = COUNT_W'($urandom_range(17, 30));
                default: setting = COUNT_W'($urandom_range(0, 31));
            endcase
            write_count(setting);
            sent = 0;
            while (sent < TRACK_ITEMS)
            begin
                len   = $urandom_range(1, 12);
                dir_x = $urandom_range(0, 1) ? 1 : -1;
                dir_y = $urandom_range(0, 1) ? 1 : -1;
                x     = $urandom();
                y     = $urandom();
                t     = $urandom_range(0, base + 8 * spacing);
                tid   = ID_W'(cur_id + int'($urandom_range(1, 4)));
                for (k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 7)
                    begin
                        send_item(make_load(SLOT_W'($urandom_range(0, 15)), $urandom()));
                    end
                    else if (r < 12)
                    begin
                        send_item(make_point(ID_W'($urandom_range(0, cur_id)), $urandom(),
                                             $urandom(), $urandom()));
                    end
                    else
                    begin
                        if ($urandom_range(0, 5) == 0) dir_x = -dir_x;
                        if ($urandom_range(0, 5) == 0) dir_y = -dir_y;
                        x = x + dir_x * $urandom_range(0, 3000);
                        y = y + dir_y * $urandom_range(0, 3000);
                        t = t + $urandom_range(0, spacing + 50);
                        send_item(make_point(tid, x, y, t));
                    end
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_long_track();
        int              k;
        logic [ID_W-1:0] tid;
        write_count('0);
        no_idle = 1'b1;
        tid = ID_W'(cur_id);
        for (k = 0; k < LONG_TRACK_POINTS; k++)
        begin
            if (k % 2 == 1)
            begin
                send_item(make_point(tid, 32'sd1, 32'sd1, $urandom()));
            end
            else
            begin
                send_item(make_point(tid, 32'sd0, 32'sd0, $urandom()));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_id_limit();
        write_count('1);
        send_item(make_point(16'hFFFF, 32'sd10, 32'sd10, 32'hFFFF_FFFF));
        send_item(make_point(16'd0, 32'sd10, 32'sd10, 32'hFFFF_FFFF));
        send_item(make_point(16'hFFFF, 32'sd20, 32'sd20, 32'd0));
        send_item(make_point(16'hFFFF, 32'sd0, 32'sd0, 32'd1));
    endtask

    always @(negedge clk)
    begin
        if (no_idle)
        begin
            seg_ch.ready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            seg_ch.ready <= 1'b0;
            ready_hold = pick_gap();
        end
        else
        begin
            seg_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end
    end

    always @(posedge clk)
    begin : check_segment
        segment_t want;
        if (rst_n === 1'b1 && seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1)
        begin
            if (pending_segments.size() == 0)
            begin
                report_failure($sformatf("unexpected segment start=%0d time=%0d number=%0d",
                                         seg_ch.seg_start, seg_ch.seg_time, seg_ch.seg_number));
            end
            else
            begin
                want = pending_segments.pop_front();
                n_checked++;
                if (seg_ch.seg_start !== want.start_idx || seg_ch.seg_time !== want.open_time
                    || seg_ch.seg_number !== want.seg_no)
                begin
                    report_failure($sformatf(
                        "segment start %0d/%0d time %0d/%0d number %0d/%0d (expected/actual)",
                        want.start_idx, seg_ch.seg_start, want.open_time, seg_ch.seg_time,
                        want.seg_no, seg_ch.seg_number));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d segments outstanding.",
                     cycle_count, pending_segments.size());
            $display("trajectory_segment_splitter_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        point_ch.valid      = 1'b0;
        point_ch.cmd        = CMD_LOAD;
        point_ch.table_slot = '0;
        point_ch.traj_id    = '0;
        point_ch.pos_x      = '0;
        point_ch.pos_y      = '0;
        point_ch.stamp      = '0;
        seg_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        for (int i = 0; i < TSS_MAX_BOUNDARIES; i++)
        begin
            bnd_value[i] = '0;
        end
        bnd_count   = '0;
        cur_id      = -1;
        last_x      = '0;
        last_y      = '0;
        heading     = FULL_MASK;
        slot_pos    = 0;
        point_idx   = '0;
        seg_idx     = '0;
        no_idle     = 1'b0;
        ready_hold  = 0;
        errors      = 0;
        cycle_count = 0;
        n_loads     = 0;
        n_points    = 0;
        n_checked   = 0;
        n_cfg       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_direction_cut();
        test_boundary_crossing();
        test_random_tracks();
        test_long_track();
        test_id_limit();
        wait_idle();

        $display("Sent %0d boundary loads and %0d points; wrote the boundary count %0d times.",
                 n_loads, n_points, n_cfg);
        $display("Checked %0d segment transfers, %0d mismatches.", n_checked, errors);
        if (errors == 0)
        begin
            $display("trajectory_segment_splitter_unit regression: pass");
        end
        else
        begin
            $display("trajectory_segment_splitter_unit regression: fail");
        end
        $finish;
    end

endmodule
